FILE: src/cpa_pkg.sv
`timescale 1ns / 1ps
package cpa_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int WIDE_W        = 66;
  localparam int QUO_W         = 32;
  localparam int REM_W         = PROD_W + QUO_W;
  localparam int CFG_W         = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [DATA_W-1:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SMIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  localparam logic [1:0] CFG_ARITH_OP     = 2'd0;
  localparam logic [1:0] CFG_USE_SCALAR   = 2'd1;
  localparam logic [1:0] CFG_COMPLEX_MODE = 2'd2;
  localparam logic [1:0] CFG_SCALAR_VALUE = 2'd3;

  typedef struct packed {
    op_t  op;
    logic use_scalar;
    logic cplx;
  } ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } sres_t;

  typedef struct packed {
    logic [PROD_W-1:0]        num;
    logic [PROD_W-1:0]        den;
    logic                     neg;
    logic                     use_div;
    logic signed [DATA_W-1:0] byp;
    logic                     sat;
    logic                     skip;
  } prep_t;

  typedef struct packed {
    logic [REM_W-1:0]         rem;
    logic [REM_W-1:0]         dsh;
    logic [QUO_W-1:0]         quo;
    logic                     ovf;
    logic                     neg;
    logic                     use_div;
    logic signed [DATA_W-1:0] byp;
    logic                     sat;
    logic                     skip;
  } div_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic sres_t sat_wide(input logic signed [WIDE_W-1:0] x);
    sres_t s;
    if (x > 66'sd2147483647) begin
      s.val = SMAX;
      s.sat = 1'b1;
    end else if (x < -66'sd2147483648) begin
      s.val = SMIN;
      s.sat = 1'b1;
    end else begin
      s.val = x[DATA_W-1:0];
      s.sat = 1'b0;
    end
    return s;
  endfunction

  // Sign and quotient magnitude (at most 2^32) to a clamped value
  function automatic sres_t sat_quo(input logic neg, input logic [QUO_W:0] q);
    sres_t s;
    if (!neg) begin
      if (q > 33'h0_7FFF_FFFF) begin
        s.val = SMAX;
        s.sat = 1'b1;
      end else begin
        s.val = q[DATA_W-1:0];
        s.sat = 1'b0;
      end
    end else begin
      if (q > 33'h0_8000_0000) begin
        s.val = SMIN;
        s.sat = 1'b1;
      end else begin
        s.val = ~q[DATA_W-1:0] + 32'sd1;
        s.sat = 1'b0;
      end
    end
    return s;
  endfunction

endpackage

FILE: src/cpa_front.sv
`timescale 1ns / 1ps
module cpa_front import cpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] a0,
  input  logic signed [DATA_W-1:0] a1,
  input  logic signed [DATA_W-1:0] b0,
  input  logic signed [DATA_W-1:0] b1,
  input  ctrl_t                    ctrl,
  input  logic signed [DATA_W-1:0] scalar,
  output div_t                     ch0,
  output div_t                     ch1
);

  function automatic logic [PROD_W-1:0] mag66(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] n;
    n = -x;
    return x[WIDE_W-1] ? n[PROD_W-1:0] : x[PROD_W-1:0];
  endfunction

  // stage 1: operands
  logic signed [DATA_W-1:0] op_a [2];
  logic signed [DATA_W-1:0] op_b [2];
  ctrl_t                    ctrl_s1;

  // stage 2: products
  logic signed [DATA_W-1:0] a_s2 [2];
  logic signed [DATA_W-1:0] b_s2 [2];
  logic signed [PROD_W-1:0] p00, p11, p01, p10, sq0, sq1;
  ctrl_t                    ctrl_s2;

  // stage 3: sign, magnitude and bypass results
  prep_t prep [2];
  prep_t prep_next [2];

  logic                     cmul, cdiv;
  logic signed [WIDE_W-1:0] mulx [2];
  logic signed [WIDE_W-1:0] cnum [2];
  logic [PROD_W-1:0]        msq;
  sres_t                    sr;

  always_ff @(posedge clk) begin
    if (en) begin
      op_a[0] <= a0;
      op_a[1] <= a1;
      op_b[0] <= ctrl.use_scalar ? scalar : b0;
      op_b[1] <= ctrl.use_scalar ? scalar : b1;
      ctrl_s1 <= ctrl;
      a_s2    <= op_a;
      b_s2    <= op_b;
      p00     <= op_a[0] * op_b[0];
      p11     <= op_a[1] * op_b[1];
      p01     <= op_a[0] * op_b[1];
      p10     <= op_a[1] * op_b[0];
      sq0     <= op_b[0] * op_b[0];
      sq1     <= op_b[1] * op_b[1];
      ctrl_s2 <= ctrl_s1;
      prep    <= prep_next;
    end
  end

  always_comb begin
    cmul = ctrl_s2.cplx && !ctrl_s2.use_scalar && (ctrl_s2.op == OP_MUL);
    cdiv = ctrl_s2.cplx && !ctrl_s2.use_scalar && (ctrl_s2.op == OP_DIV);
    mulx[0] = cmul ? (WIDE_W'(p00) - WIDE_W'(p11)) : WIDE_W'(p00);
    mulx[1] = cmul ? (WIDE_W'(p01) + WIDE_W'(p10)) : WIDE_W'(p11);
    cnum[0] = WIDE_W'(p00) + WIDE_W'(p11);
    cnum[1] = WIDE_W'(p10) - WIDE_W'(p01);
    msq     = $unsigned(sq0) + $unsigned(sq1);
    sr      = '0;
    for (int c = 0; c < 2; c++) begin
      prep_next[c] = '0;
      case (ctrl_s2.op)
        OP_ADD: begin
          sr = sat_wide(WIDE_W'(a_s2[c]) + WIDE_W'(b_s2[c]));
          prep_next[c].byp = sr.val;
          prep_next[c].sat = sr.sat;
        end
        OP_SUB: begin
          sr = sat_wide(WIDE_W'(a_s2[c]) - WIDE_W'(b_s2[c]));
          prep_next[c].byp = sr.val;
          prep_next[c].sat = sr.sat;
        end
        OP_MUL: begin
          sr = sat_wide(mulx[c] >>> FRAC_BITS);
          prep_next[c].byp = sr.val;
          prep_next[c].sat = sr.sat;
        end
        default: begin
          if (cdiv) begin
            if (msq == '0) begin
              prep_next[c].byp  = a_s2[c];
              prep_next[c].skip = 1'b1;
            end else begin
              prep_next[c].num     = mag66(cnum[c]);
              prep_next[c].den     = msq;
              prep_next[c].neg     = cnum[c][WIDE_W-1];
              prep_next[c].use_div = 1'b1;
            end
          end else if (b_s2[c] != '0) begin
            prep_next[c].num     = mag66(WIDE_W'(a_s2[c]));
            prep_next[c].den     = mag66(WIDE_W'(b_s2[c]));
            prep_next[c].neg     = a_s2[c][DATA_W-1] ^ b_s2[c][DATA_W-1];
            prep_next[c].use_div = 1'b1;
          end else if (ctrl_s2.use_scalar) begin
            prep_next[c].sat = 1'b1;
            if (a_s2[c] == '0) begin
              prep_next[c].byp = '0;
            end else begin
              prep_next[c].byp = a_s2[c][DATA_W-1] ? SMIN : SMAX;
            end
          end else begin
            prep_next[c].byp  = a_s2[c];
            prep_next[c].skip = 1'b1;
          end
        end
      endcase
    end
  end

  // stage 4: scale the dividend, align the divisor, catch quotients of 2^32 or more
  function automatic div_t load(input prep_t p);
    div_t d;
    d.rem     = REM_W'(p.num) << FRAC_BITS;
    d.dsh     = REM_W'(p.den) << (QUO_W - 1);
    d.ovf     = (REM_W'(p.num) << FRAC_BITS) >= (REM_W'(p.den) << QUO_W);
    d.quo     = '0;
    d.neg     = p.neg;
    d.use_div = p.use_div;
    d.byp     = p.byp;
    d.sat     = p.sat;
    d.skip    = p.skip;
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ch0 <= load(prep[0]);
      ch1 <= load(prep[1]);
    end
  end

endmodule

FILE: src/cpa_cell.sv
`timescale 1ns / 1ps
module cpa_cell import cpa_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  div_t dnext;

  // one restoring step: subtract the aligned divisor if it fits, then halve it
  always_comb begin
    dnext     = din;
    dnext.dsh = din.dsh >> 1;
    if (din.rem >= din.dsh) begin
      dnext.rem = din.rem - din.dsh;
      dnext.quo = {din.quo[QUO_W-2:0], 1'b1};
    end else begin
      dnext.quo = {din.quo[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dnext;
    end
  end

endmodule

FILE: src/complex_pixel_arithmetic.sv
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents (lowest bits first)
// s_        in   128    a_chan0, a_chan1, b_chan0, b_chan1
// m_        out  64+2   tdata: r_chan0, r_chan1; tuser: divide_skipped, saturated
// cfg_      in   2+32   index, data; written when cfg_we is high
//
// One item per cycle while the skid register is empty. Stages in order: two operand/product stages,
// two set-up stages, one divider cell per quotient bit, one output register.
// rst clears the configuration and all valid bits.
// A skid register behind the output takes one item while m_tready is low;
// the chain stops only once the skid register is full.
module complex_pixel_arithmetic import cpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [4*DATA_W-1:0]   s_tdata,   // a_chan0, a_chan1, b_chan0, b_chan1
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [2*DATA_W-1:0]   m_tdata,   // r_chan0, r_chan1
  output logic [1:0]            m_tuser,   // divide_skipped, saturated
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int NV = 4 + QUO_W;

  op_t                      arith_op;
  logic                     use_scalar;
  logic                     complex_mode;
  logic signed [DATA_W-1:0] scalar_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      arith_op     <= OP_ADD;
      use_scalar   <= 1'b0;
      complex_mode <= 1'b0;
      scalar_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARITH_OP:     arith_op     <= op_t'(cfg_data[1:0]);
        CFG_USE_SCALAR:   use_scalar   <= cfg_data[0];
        CFG_COMPLEX_MODE: complex_mode <= cfg_data[0];
        CFG_SCALAR_VALUE: scalar_value <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  logic  go;
  logic  [NV-1:0] v;
  ctrl_t ctrl;
  div_t  chain0 [QUO_W+1];
  div_t  chain1 [QUO_W+1];

  assign ctrl = '{op: arith_op, use_scalar: use_scalar, cplx: complex_mode};

  cpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .en     (go),
    .a0     (s_tdata[DATA_W-1:0]),
    .a1     (s_tdata[2*DATA_W-1:DATA_W]),
    .b0     (s_tdata[3*DATA_W-1:2*DATA_W]),
    .b1     (s_tdata[4*DATA_W-1:3*DATA_W]),
    .ctrl   (ctrl),
    .scalar (scalar_value),
    .ch0    (chain0[0]),
    .ch1    (chain1[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    cpa_cell u_c0 (.clk(clk), .en(go), .din(chain0[k]), .dout(chain0[k+1]));
    cpa_cell u_c1 (.clk(clk), .en(go), .din(chain1[k]), .dout(chain1[k+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (go) begin
      v <= {v[NV-2:0], s_tvalid};
    end
  end

  // result assembly
  sres_t             f0, f1;
  logic [QUO_W:0]    q0, q1;
  logic [2*DATA_W-1:0] fin_data;
  logic [1:0]        fin_user;

  always_comb begin
    q0 = chain0[QUO_W].ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, chain0[QUO_W].quo};
    q1 = chain1[QUO_W].ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, chain1[QUO_W].quo};
    f0 = chain0[QUO_W].use_div ? sat_quo(chain0[QUO_W].neg, q0)
                               : '{val: chain0[QUO_W].byp, sat: chain0[QUO_W].sat};
    f1 = chain1[QUO_W].use_div ? sat_quo(chain1[QUO_W].neg, q1)
                               : '{val: chain1[QUO_W].byp, sat: chain1[QUO_W].sat};
    fin_data = {f1.val, f0.val};
    fin_user = {f0.sat | f1.sat, chain0[QUO_W].skip | chain1[QUO_W].skip};
  end

  logic                arrive;
  logic                out_free;
  logic                skid_v;
  logic [2*DATA_W-1:0] skid_data;
  logic [1:0]          skid_user;

  assign go       = !skid_v;
  assign s_tready = go;
  assign arrive   = go && v[NV-1];
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (out_free) begin
      if (skid_v) begin
        skid_v <= 1'b0;
      end else begin
        m_tvalid <= arrive;
      end
    end else if (arrive) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= fin_data;
        m_tuser <= fin_user;
      end
    end else if (arrive) begin
      skid_data <= fin_data;
      skid_user <= fin_user;
    end
  end

  // the skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> m_tvalid)
    else $error("skid register full while output empty");

  // a stalled output with an item arriving parks it in the skid register
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && arrive) |=> skid_v)
    else $error("arriving item not caught by skid register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !skid_v && (v == '0)))
    else $error("pipeline not empty after reset");

endmodule
